// ----- rtl/core/bss_pkg.sv -----
// package for the baud scale/step search core
// shared widths, register map, controller states and command/status types
// no dependencies
`timescale 1ns / 1ps

package bss_pkg;

    // field widths
    localparam int BAUD_W     = 24;
    localparam int CLK_W      = 28;
    localparam int SCALE_W    = 8;
    localparam int STEP_OUT_W = 16;
    localparam int FRAC_SHIFT = 17;

    // baud * (scale + 1) and the shared divider operands
    localparam int MULT_W     = BAUD_W + SCALE_W + 1;
    localparam int DIV_NUM_W  = MULT_W + FRAC_SHIFT;
    localparam int DIV_DEN_W  = CLK_W;

    // parameter defaults
    localparam int DEF_SCALE_COUNT = 255;
    localparam int DEF_STEP_MAX    = 65535;

    // register file
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_REF_CLOCK = '0;
    localparam logic [CLK_W-1:0]     REF_CLOCK_RESET = 28'd25000000;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV1_GO,
        ST_DIV1_WAIT,
        ST_CHECK,
        ST_MUL,
        ST_DIV2_GO,
        ST_DIV2_WAIT,
        ST_ERR,
        ST_UPDATE,
        ST_FINISH
    } bss_state_t;

    // divider operand select
    typedef enum logic {
        DIV_STEP,
        DIV_BAUD
    } bss_div_sel_t;

    // controller to datapath
    typedef struct packed {
        logic         load;
        logic         div_start;
        bss_div_sel_t div_sel;
        logic         step_load;
        logic         prod_load;
        logic         err_load;
        logic         update;
        logic         out_load;
    } bss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic clk_zero;
        logic step_over;
        logic last_scale;
    } bss_status_t;

endpackage

// ----- rtl/core/baud_scale_step_search_core.sv -----
// top level of the baud scale/step search core: config register and instances
// depends on bss_pkg, bss_ctrl, bss_datapath, bss_div
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   --------------------------
//  in        input      in_valid / in_ready     target_baud
//  out       output     out_valid / out_ready   best_scale, best_step
//  cfg       input      apb psel/penable        paddr, pwdata -> prdata
//
//  each candidate scale runs two divisions on the shared restoring divider
//  (50 steps each, then the wait state that sees done), one for the step
//  and one for the achieved baud, between the control states
//  a zero reference clock skips the search and goes straight to the result;
//  the search ends early at the first step overflow
//  rst_n clears the controller and the divider control, and sets ref_clock_reg to 25 MHz
//  a finished result waits in the output register while the next
//  transaction is taken; the core stalls at the end of a search only while
//  that register is still full

module baud_scale_step_search_core #(
    parameter int SCALE_COUNT = bss_pkg::DEF_SCALE_COUNT,
    parameter int STEP_MAX    = bss_pkg::DEF_STEP_MAX
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bss_pkg::BAUD_W-1:0]     target_baud,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bss_pkg::SCALE_W-1:0]    best_scale,
    output logic [bss_pkg::STEP_OUT_W-1:0] best_step,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bss_pkg::PADDR_W-1:0]    paddr,
    input  logic [bss_pkg::PDATA_W-1:0]    pwdata,
    output logic [bss_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    import bss_pkg::*;

    logic [CLK_W-1:0]     ref_clock_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;
    bss_cmd_t             cmd;
    bss_status_t          status;

    // register port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_clock_reg <= REF_CLOCK_RESET;
        else if (cfg_write && (reg_idx == REG_REF_CLOCK))
            ref_clock_reg <= pwdata[CLK_W-1:0];
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_REF_CLOCK:
                prdata = PDATA_W'(ref_clock_reg);
            default:
                prdata = '0;
        endcase
    end

    bss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bss_datapath #(
        .SCALE_COUNT (SCALE_COUNT),
        .STEP_MAX    (STEP_MAX)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .ref_clock   (ref_clock_reg),
        .target_baud (target_baud),
        .best_scale  (best_scale),
        .best_step   (best_step)
    );

endmodule

// ----- rtl/core/bss_div.sv -----
// restoring divider, one quotient bit per cycle
// shared by the step and achieved baud computations; standalone, no package needed
`timescale 1ns / 1ps

module bss_div #(
    parameter int NUM_W = 50,
    parameter int DEN_W = 28
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [NUM_W-1:0] num_reg, num_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   trial;
    logic             fits;

    // one restoring step
    assign trial = {rem_reg, num_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = CNT_W'(NUM_W);
            num_next   = num;
            rem_next   = '0;
            den_next   = den;
        end
        else if (busy_reg)
        begin
            num_next   = {num_reg[NUM_W-2:0], fits};
            rem_next   = fits ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            count_next = count_reg - 1'b1;
            if (count_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    // operand and partial remainder
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

`ifndef NO_ASSERTIONS
    // a new division never cuts into one in progress
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider restarted while busy");

    // done only right after the last step
    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("divider done without a run");

    // a running division always has steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg != '0))
        else $error("divider busy with zero count");
`endif

endmodule

// ----- rtl/core/bss_datapath.sv -----
// datapath of the baud scale/step search: operands, shared divider, best pair
// depends on bss_pkg and bss_div
`timescale 1ns / 1ps

module bss_datapath #(
    parameter int SCALE_COUNT = bss_pkg::DEF_SCALE_COUNT,
    parameter int STEP_MAX    = bss_pkg::DEF_STEP_MAX
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bss_pkg::bss_cmd_t              cmd,
    output bss_pkg::bss_status_t           status,
    input  logic [bss_pkg::CLK_W-1:0]      ref_clock,
    input  logic [bss_pkg::BAUD_W-1:0]     target_baud,
    output logic [bss_pkg::SCALE_W-1:0]    best_scale,
    output logic [bss_pkg::STEP_OUT_W-1:0] best_step
);

    import bss_pkg::*;

    localparam int STEP_W = $clog2(STEP_MAX + 1);
    localparam int MUL_W  = CLK_W + STEP_W;
    localparam int PROD_W = MUL_W + 1;
    localparam int GOT_W  = PROD_W - FRAC_SHIFT;
    localparam int ERR_W  = (GOT_W > BAUD_W) ? GOT_W : BAUD_W;

    logic [BAUD_W-1:0]    baud_reg;
    logic [MULT_W-1:0]    mult_reg;
    logic [SCALE_W-1:0]   scale_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [ERR_W-1:0]     err_reg;
    logic [ERR_W-1:0]     best_err_reg;
    logic [SCALE_W-1:0]   best_scale_reg;
    logic [STEP_W-1:0]    best_step_reg;
    logic [SCALE_W-1:0]   out_scale_reg;
    logic [STEP_OUT_W-1:0] out_step_reg;

    logic [SCALE_W:0]     scale_plus1;
    logic [MUL_W-1:0]     mul;
    logic [PROD_W-1:0]    prod_next;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic [DIV_NUM_W-1:0] quot;
    logic                 div_done;
    logic [ERR_W-1:0]     got_e;
    logic [ERR_W-1:0]     baud_e;
    logic [ERR_W-1:0]     err_next;

    assign scale_plus1 = {1'b0, scale_reg} + 1'b1;

    // divider operands: step search or achieved baud
    always_comb
    begin
        case (cmd.div_sel)
            DIV_STEP:
            begin
                div_num = {mult_reg, {FRAC_SHIFT{1'b0}}};
                div_den = ref_clock;
            end
            DIV_BAUD:
            begin
                div_num = DIV_NUM_W'(prod_reg[PROD_W-1:FRAC_SHIFT]);
                div_den = DIV_DEN_W'(scale_plus1);
            end
            default:
            begin
                div_num = '0;
                div_den = '0;
            end
        endcase
    end

    bss_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    // ref_clock * step plus half the divisor, rounding to nearest
    assign mul       = ref_clock * step_reg;
    assign prod_next = PROD_W'(mul) + PROD_W'({scale_plus1, {(FRAC_SHIFT - 1){1'b0}}});

    // absolute error of the achieved baud
    assign got_e    = ERR_W'(quot[GOT_W-1:0]);
    assign baud_e   = ERR_W'(baud_reg);
    assign err_next = (got_e >= baud_e) ? (got_e - baud_e) : (baud_e - got_e);

    // search registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            baud_reg       <= target_baud;
            mult_reg       <= MULT_W'(target_baud);
            scale_reg      <= '0;
            best_err_reg   <= ERR_W'(target_baud);
            best_scale_reg <= '0;
            best_step_reg  <= '0;
        end
        if (cmd.step_load)
            step_reg <= quot[STEP_W-1:0];
        if (cmd.prod_load)
            prod_reg <= prod_next;
        if (cmd.err_load)
            err_reg <= err_next;
        if (cmd.update)
        begin
            if (err_reg < best_err_reg)
            begin
                best_err_reg   <= err_reg;
                best_scale_reg <= scale_reg;
                best_step_reg  <= step_reg;
            end
            scale_reg <= scale_reg + 1'b1;
            mult_reg  <= mult_reg + MULT_W'(baud_reg);
        end
        if (cmd.out_load)
        begin
            out_scale_reg <= best_scale_reg;
            out_step_reg  <= STEP_OUT_W'(best_step_reg);
        end
    end

    // status to the controller
    assign status.div_done   = div_done;
    assign status.clk_zero   = (ref_clock == '0);
    assign status.step_over  = quot > DIV_NUM_W'(STEP_MAX);
    assign status.last_scale = (scale_reg == SCALE_W'(SCALE_COUNT - 1));

    assign best_scale = out_scale_reg;
    assign best_step  = out_step_reg;

endmodule

// ----- rtl/core/bss_ctrl.sv -----
// sequencing controller of the baud scale/step search
// depends on bss_pkg for states and command/status types
`timescale 1ns / 1ps

module bss_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  bss_pkg::bss_status_t status,
    output bss_pkg::bss_cmd_t    cmd
);

    import bss_pkg::*;

    bss_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = status.clk_zero ? ST_FINISH : ST_DIV1_GO;
            ST_DIV1_GO:
                state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT:
                if (status.div_done)
                    state_next = ST_CHECK;
            ST_CHECK:
                state_next = status.step_over ? ST_FINISH : ST_MUL;
            ST_MUL:
                state_next = ST_DIV2_GO;
            ST_DIV2_GO:
                state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT:
                if (status.div_done)
                    state_next = ST_ERR;
            ST_ERR:
                state_next = ST_UPDATE;
            ST_UPDATE:
                state_next = status.last_scale ? ST_FINISH : ST_DIV1_GO;
            ST_FINISH:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_DIV1_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_STEP;
            end
            ST_DIV1_WAIT:
                cmd.div_sel = DIV_STEP;
            ST_CHECK:
                cmd.step_load = 1'b1;
            ST_MUL:
                cmd.prod_load = 1'b1;
            ST_DIV2_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_BAUD;
            end
            ST_DIV2_WAIT:
                cmd.div_sel = DIV_BAUD;
            ST_ERR:
                cmd.err_load = 1'b1;
            ST_UPDATE:
                cmd.update = 1'b1;
            ST_FINISH:
                cmd.out_load = out_free;
            default:
                cmd = '0;
        endcase
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule
